/* design/spfm_pkg.sv */
// ----------------------------------------------------------------------------
// spfm_pkg
// Shared sizes, codes and types of the strict priority frame multiplexer.
// ----------------------------------------------------------------------------
`default_nettype none

package spfm_pkg;

  localparam int NUM_PRIOS   = 8;
  localparam int PRIO_W      = 3;
  localparam int QUEUE_DEPTH = 64;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;
  localparam int ADDR_W      = PRIO_W + SLOT_W;
  localparam int STORE_DEPTH = NUM_PRIOS * QUEUE_DEPTH;
  localparam int FRAME_W     = 33;
  localparam int LEN_W       = 14;
  localparam int TAG_W       = 16;
  localparam int TICKS_W     = 24;
  localparam int BYTES_W     = 20;
  localparam int DROPS_W     = 32;
  localparam int DIV_NUM_W   = 20;
  localparam int DIV_DEN_W   = 17;
  localparam int DIV_CNT_W   = 5;

  // configuration register indexes
  localparam logic [2:0] CFG_SYNC_MODE     = 3'd0;
  localparam logic [2:0] CFG_SERVICE_TICKS = 3'd1;
  localparam logic [2:0] CFG_BITS_PER_TICK = 3'd2;
  localparam logic [2:0] CFG_CODE_MAP      = 3'd3;
  localparam logic [2:0] CFG_LIMITS_LOW    = 3'd4;
  localparam logic [2:0] CFG_LIMITS_HIGH   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEQ,
    ST_DIV,
    ST_DIVEND,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SERVING,
    MODE_SYNCING
  } mode_t;

  typedef enum logic [1:0] {
    DIV_PHASE,
    DIV_ARRIVAL,
    DIV_DEQUEUE
  } div_use_t;

endpackage

`default_nettype wire

/* design/strict_priority_frame_mux.sv */
// ----------------------------------------------------------------------------
// strict_priority_frame_mux
// Strict priority scheduler: eight bounded FIFOs in one frame store, one server.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    action, code_point, frame_len, frame_tag
//  out      output     out_valid / out_ready  departed, tags, prios, dropped, fill
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one request at a time; a queued or dropped arrival, a plain tick and a tick
//  with a sync dequeue finish without the divider, while an arrival at an idle
//  server (async service time or sync phase modulo) and a tick with an async
//  dequeue pass through the 20 steps of the serial divider
//  the frame store is a single-port-read synchronous ram with a registered read
//  reset is synchronous, active low; the store needs no clearing pass
//  a held result sits in the output register; a new request is taken meanwhile
`default_nettype none

module strict_priority_frame_mux (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [2:0]  in_code_point,
  input  wire logic [13:0] in_frame_len,
  input  wire logic [15:0] in_frame_tag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_departed,
  output logic [15:0]      out_depart_tag,
  output logic [2:0]       out_depart_prio,
  output logic             out_dropped,
  output logic [2:0]       out_arrival_prio,
  output logic [6:0]       out_queue_fill,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int NP = spfm_pkg::NUM_PRIOS;
  localparam int PW = spfm_pkg::PRIO_W;
  localparam int CW = spfm_pkg::COUNT_W;
  localparam int SW = spfm_pkg::SLOT_W;
  localparam int AW = spfm_pkg::ADDR_W;
  localparam int FW = spfm_pkg::FRAME_W;
  localparam int LW = spfm_pkg::LEN_W;
  localparam int TW = spfm_pkg::TAG_W;
  localparam int KW = spfm_pkg::TICKS_W;
  localparam int BW = spfm_pkg::BYTES_W;
  localparam int DW = spfm_pkg::DROPS_W;
  localparam int NW = spfm_pkg::DIV_NUM_W;
  localparam int EW = spfm_pkg::DIV_DEN_W;
  localparam int XW = spfm_pkg::DIV_CNT_W;

  // configuration registers
  logic        sync_mode_r;
  logic [15:0] service_ticks_r;
  logic [15:0] bits_per_tick_r;
  logic [23:0] code_map_r;
  logic [63:0] limits_low_r;
  logic [63:0] limits_high_r;

  // control and server state
  spfm_pkg::state_t   state_r, state_nxt;
  spfm_pkg::mode_t    mode_r, mode_nxt;
  spfm_pkg::div_use_t div_use_r, div_use_nxt;
  logic [FW-1:0]      server_frame_r, server_frame_nxt;
  logic [KW-1:0]      ticks_r, ticks_nxt;
  logic [15:0]        phase_r, phase_nxt;
  logic [PW-1:0]      deq_prio_r, deq_prio_nxt;

  // per-priority queue state
  logic [CW-1:0] counts_r [NP];
  logic [CW-1:0] counts_nxt [NP];
  logic [SW-1:0] heads_r [NP];
  logic [SW-1:0] heads_nxt [NP];
  logic [BW-1:0] bytes_r [NP];
  logic [BW-1:0] bytes_nxt [NP];
  logic [DW-1:0] drops_r [NP];
  logic [DW-1:0] drops_nxt [NP];

  // latched request
  logic          lat_action_r;
  logic [2:0]    lat_cp_r;
  logic [LW-1:0] lat_len_r;
  logic [TW-1:0] lat_tag_r;

  // result being built and output register
  logic          res_departed_r, res_departed_nxt;
  logic [TW-1:0] res_dtag_r, res_dtag_nxt;
  logic [PW-1:0] res_dprio_r, res_dprio_nxt;
  logic          res_dropped_r, res_dropped_nxt;
  logic [PW-1:0] res_aprio_r, res_aprio_nxt;
  logic [CW-1:0] res_fill_r, res_fill_nxt;
  logic          out_valid_r;

  // frame store
  logic [FW-1:0] frame_store [spfm_pkg::STORE_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [FW-1:0] mem_wdata;
  logic [FW-1:0] rd_data_r;

  // serial divider
  logic [NW-1:0] dv_quo_r, dv_quo_nxt;
  logic [EW:0]   dv_rem_r, dv_rem_nxt;
  logic [EW-1:0] dv_den_r, dv_den_nxt;
  logic [XW-1:0] dv_cnt_r, dv_cnt_nxt;
  logic [EW:0]   dv_trial;

  // derived values
  logic [PW-1:0] map_entry [8];
  logic [PW-1:0] arr_prio;
  logic [15:0]   lim_raw;
  logic [CW-1:0] lim_eff;
  logic [FW-1:0] frame_lat;
  logic [15:0]   period;
  logic [15:0]   rate;
  logic [PW-1:0] sel_prio;
  logic          any_queued;
  logic [SW-1:0] enq_slot;
  logic [16:0]   phase_inc;
  logic [KW-1:0] div_ticks;

  assign in_ready  = (state_r == spfm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // code point map, limits, effective period and rate
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      map_entry[k] = code_map_r[3*k +: 3];
    end
    arr_prio = map_entry[lat_cp_r];
    if (arr_prio[2]) begin
      lim_raw = limits_high_r[16*arr_prio[1:0] +: 16];
    end else begin
      lim_raw = limits_low_r[16*arr_prio[1:0] +: 16];
    end
    if (lim_raw == 16'd0) begin
      lim_eff = CW'(1);
    end else if (lim_raw > 16'(spfm_pkg::QUEUE_DEPTH)) begin
      lim_eff = CW'(spfm_pkg::QUEUE_DEPTH);
    end else begin
      lim_eff = lim_raw[CW-1:0];
    end
    frame_lat = {arr_prio, lat_len_r, lat_tag_r};
    period    = (service_ticks_r == 16'd0) ? 16'd1 : service_ticks_r;
    rate      = (bits_per_tick_r == 16'd0) ? 16'd1 : bits_per_tick_r;
    enq_slot  = heads_r[arr_prio] + counts_r[arr_prio][SW-1:0];
    phase_inc = {1'b0, phase_r} + 17'd1;
    div_ticks = (dv_quo_r == '0) ? KW'(1) : KW'(dv_quo_r);
  end

  // highest non-empty queue
  always_comb begin
    sel_prio   = '0;
    any_queued = 1'b0;
    for (int k = 0; k < NP; k++) begin
      if (counts_r[k] != '0) begin
        sel_prio   = PW'(k);
        any_queued = 1'b1;
      end
    end
  end

  assign dv_trial = {dv_rem_r[EW-1:0], dv_quo_r[NW-1]};

  // next state and datapath updates
  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    div_use_nxt      = div_use_r;
    server_frame_nxt = server_frame_r;
    ticks_nxt        = ticks_r;
    phase_nxt        = phase_r;
    deq_prio_nxt     = deq_prio_r;
    counts_nxt       = counts_r;
    heads_nxt        = heads_r;
    bytes_nxt        = bytes_r;
    drops_nxt        = drops_r;
    res_departed_nxt = res_departed_r;
    res_dtag_nxt     = res_dtag_r;
    res_dprio_nxt    = res_dprio_r;
    res_dropped_nxt  = res_dropped_r;
    res_aprio_nxt    = res_aprio_r;
    res_fill_nxt     = res_fill_r;
    mem_we           = 1'b0;
    mem_waddr        = {arr_prio, enq_slot};
    mem_wdata        = frame_lat;
    mem_re           = 1'b0;
    mem_raddr        = {sel_prio, heads_r[sel_prio]};
    dv_quo_nxt       = dv_quo_r;
    dv_rem_nxt       = dv_rem_r;
    dv_den_nxt       = dv_den_r;
    dv_cnt_nxt       = dv_cnt_r;

    case (state_r)
      spfm_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_departed_nxt = 1'b0;
          res_dtag_nxt     = '0;
          res_dprio_nxt    = '0;
          res_dropped_nxt  = 1'b0;
          res_aprio_nxt    = '0;
          res_fill_nxt     = '0;
          state_nxt        = spfm_pkg::ST_EXEC;
        end
      end

      spfm_pkg::ST_EXEC: begin
        if (!lat_action_r) begin
          // frame arrival
          res_aprio_nxt = arr_prio;
          dv_rem_nxt    = '0;
          dv_cnt_nxt    = '0;
          if (mode_r == spfm_pkg::MODE_IDLE) begin
            if (sync_mode_r) begin
              dv_quo_nxt  = NW'(phase_r);
              dv_den_nxt  = EW'(period);
              div_use_nxt = spfm_pkg::DIV_PHASE;
            end else begin
              dv_quo_nxt  = NW'({lat_len_r, 4'b0000}) + NW'(rate);
              dv_den_nxt  = {rate, 1'b0};
              div_use_nxt = spfm_pkg::DIV_ARRIVAL;
            end
            state_nxt = spfm_pkg::ST_DIV;
          end else if (counts_r[arr_prio] < lim_eff) begin
            mem_we                = 1'b1;
            counts_nxt[arr_prio]  = counts_r[arr_prio] + CW'(1);
            bytes_nxt[arr_prio]   = bytes_r[arr_prio] + BW'(lat_len_r);
            res_fill_nxt          = counts_r[arr_prio] + CW'(1);
            state_nxt             = spfm_pkg::ST_OUT;
          end else begin
            drops_nxt[arr_prio] = drops_r[arr_prio] + DW'(1);
            res_dropped_nxt     = 1'b1;
            res_fill_nxt        = counts_r[arr_prio];
            state_nxt           = spfm_pkg::ST_OUT;
          end
        end else begin
          // time tick
          phase_nxt = (phase_inc >= {1'b0, period}) ? 16'd0 : phase_inc[15:0];
          state_nxt = spfm_pkg::ST_OUT;
          if (mode_r == spfm_pkg::MODE_IDLE) begin
            state_nxt = spfm_pkg::ST_OUT;
          end else if (ticks_r > KW'(1)) begin
            ticks_nxt = ticks_r - KW'(1);
          end else begin
            ticks_nxt = '0;
            if (mode_r == spfm_pkg::MODE_SERVING) begin
              res_departed_nxt = 1'b1;
              res_dtag_nxt     = server_frame_r[TW-1:0];
              res_dprio_nxt    = server_frame_r[FW-1 -: PW];
            end
            if (any_queued) begin
              mem_re               = 1'b1;
              heads_nxt[sel_prio]  = heads_r[sel_prio] + SW'(1);
              counts_nxt[sel_prio] = counts_r[sel_prio] - CW'(1);
              deq_prio_nxt         = sel_prio;
              state_nxt            = spfm_pkg::ST_DEQ;
            end else begin
              if (mode_r == spfm_pkg::MODE_SERVING) begin
                server_frame_nxt = '0;
              end
              mode_nxt = spfm_pkg::MODE_IDLE;
            end
          end
        end
      end

      spfm_pkg::ST_DEQ: begin
        // read data of the dequeued frame is valid now
        server_frame_nxt       = rd_data_r;
        bytes_nxt[deq_prio_r]  = bytes_r[deq_prio_r] - BW'(rd_data_r[TW +: LW]);
        if (sync_mode_r || (mode_r == spfm_pkg::MODE_SYNCING)) begin
          ticks_nxt = KW'(period);
          mode_nxt  = spfm_pkg::MODE_SERVING;
          state_nxt = spfm_pkg::ST_OUT;
        end else begin
          dv_quo_nxt  = NW'({rd_data_r[TW +: LW], 4'b0000}) + NW'(rate);
          dv_den_nxt  = {rate, 1'b0};
          dv_rem_nxt  = '0;
          dv_cnt_nxt  = '0;
          div_use_nxt = spfm_pkg::DIV_DEQUEUE;
          state_nxt   = spfm_pkg::ST_DIV;
        end
      end

      spfm_pkg::ST_DIV: begin
        // one restoring step per cycle
        if (dv_trial >= {1'b0, dv_den_r}) begin
          dv_rem_nxt = dv_trial - {1'b0, dv_den_r};
          dv_quo_nxt = {dv_quo_r[NW-2:0], 1'b1};
        end else begin
          dv_rem_nxt = dv_trial;
          dv_quo_nxt = {dv_quo_r[NW-2:0], 1'b0};
        end
        dv_cnt_nxt = dv_cnt_r + XW'(1);
        if (dv_cnt_r == XW'(NW - 1)) begin
          state_nxt = spfm_pkg::ST_DIVEND;
        end
      end

      spfm_pkg::ST_DIVEND: begin
        state_nxt = spfm_pkg::ST_OUT;
        case (div_use_r)
          spfm_pkg::DIV_PHASE: begin
            if (dv_rem_r[15:0] != 16'd0) begin
              mem_we               = 1'b1;
              counts_nxt[arr_prio] = counts_r[arr_prio] + CW'(1);
              bytes_nxt[arr_prio]  = bytes_r[arr_prio] + BW'(lat_len_r);
              res_fill_nxt         = counts_r[arr_prio] + CW'(1);
              ticks_nxt            = KW'(period - dv_rem_r[15:0]);
              mode_nxt             = spfm_pkg::MODE_SYNCING;
            end else begin
              server_frame_nxt = frame_lat;
              ticks_nxt        = KW'(period);
              mode_nxt         = spfm_pkg::MODE_SERVING;
              res_fill_nxt     = counts_r[arr_prio];
            end
          end
          spfm_pkg::DIV_ARRIVAL: begin
            server_frame_nxt = frame_lat;
            ticks_nxt        = div_ticks;
            mode_nxt         = spfm_pkg::MODE_SERVING;
            res_fill_nxt     = counts_r[arr_prio];
          end
          default: begin
            ticks_nxt = div_ticks;
          end
        endcase
      end

      spfm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = spfm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = spfm_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spfm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state, queue state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= spfm_pkg::MODE_IDLE;
      server_frame_r  <= '0;
      ticks_r         <= '0;
      phase_r         <= '0;
      out_valid_r     <= 1'b0;
      sync_mode_r     <= 1'b0;
      service_ticks_r <= 16'd1;
      bits_per_tick_r <= 16'd8;
      code_map_r      <= 24'd16434824;
      limits_low_r    <= 64'd281479271743489;
      limits_high_r   <= 64'd281479271743489;
      for (int k = 0; k < NP; k++) begin
        counts_r[k] <= '0;
        heads_r[k]  <= '0;
        bytes_r[k]  <= '0;
        drops_r[k]  <= '0;
      end
    end else begin
      mode_r         <= mode_nxt;
      server_frame_r <= server_frame_nxt;
      ticks_r        <= ticks_nxt;
      phase_r        <= phase_nxt;
      counts_r       <= counts_nxt;
      heads_r        <= heads_nxt;
      bytes_r        <= bytes_nxt;
      drops_r        <= drops_nxt;
      if (state_r == spfm_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          spfm_pkg::CFG_SYNC_MODE:     sync_mode_r     <= cfg_data[0];
          spfm_pkg::CFG_SERVICE_TICKS: service_ticks_r <= cfg_data[15:0];
          spfm_pkg::CFG_BITS_PER_TICK: bits_per_tick_r <= cfg_data[15:0];
          spfm_pkg::CFG_CODE_MAP:      code_map_r      <= cfg_data[23:0];
          spfm_pkg::CFG_LIMITS_LOW:    limits_low_r    <= cfg_data;
          spfm_pkg::CFG_LIMITS_HIGH:   limits_high_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lat_action_r <= in_action;
      lat_cp_r     <= in_code_point;
      lat_len_r    <= in_frame_len;
      lat_tag_r    <= in_frame_tag;
    end
    div_use_r      <= div_use_nxt;
    deq_prio_r     <= deq_prio_nxt;
    dv_quo_r       <= dv_quo_nxt;
    dv_rem_r       <= dv_rem_nxt;
    dv_den_r       <= dv_den_nxt;
    dv_cnt_r       <= dv_cnt_nxt;
    res_departed_r <= res_departed_nxt;
    res_dtag_r     <= res_dtag_nxt;
    res_dprio_r    <= res_dprio_nxt;
    res_dropped_r  <= res_dropped_nxt;
    res_aprio_r    <= res_aprio_nxt;
    res_fill_r     <= res_fill_nxt;
    if (state_r == spfm_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
      out_departed     <= res_departed_r;
      out_depart_tag   <= res_dtag_r;
      out_depart_prio  <= res_dprio_r;
      out_dropped      <= res_dropped_r;
      out_arrival_prio <= res_aprio_r;
      out_queue_fill   <= res_fill_r;
    end
  end

  assign out_valid = out_valid_r;

  // frame store, synchronous write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= frame_store[mem_raddr];
    end
  end

  // checks
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_deq_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spfm_pkg::ST_DEQ) |-> $past(mem_re))
    else $error("dequeue without a store read");

  a_serving_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spfm_pkg::ST_IDLE && mode_r != spfm_pkg::MODE_IDLE) |-> (ticks_r != '0))
    else $error("busy server with no time left");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spfm_pkg::ST_OUT) |-> (res_fill_r <= CW'(spfm_pkg::QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

endmodule

`default_nettype wire
